FILE: rtl/ffa_pkg.sv
package ffa_pkg;

  localparam int MEM_CELLS   = 128;
  localparam int MAX_HANDLES = 255;
  localparam int CELL_AW     = $clog2(MEM_CELLS);
  localparam int CNT_W       = $clog2(MEM_CELLS + 1);
  localparam int HND_W       = $clog2(MAX_HANDLES + 1);
  localparam int HND_DEPTH   = 1 << HND_W;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_DEFRAG = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_ILLEGAL  = 2'd2;
  localparam logic [1:0] ST_NO_HND   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CELL_RD,
    OP_A_EVAL,
    OP_FILL,
    OP_TAB_RD,
    OP_E_LOAD,
    OP_E_CLR,
    OP_D_EVAL,
    OP_D_CLR,
    OP_RES,
    OP_PUSH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] res_code;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       no_hnd;
    logic       size_zero;
    logic       hnd_ok;
    logic       scan_end;
    logic       hit;
    logic       fill_last;
    logic       defrag_end;
    logic       clr_end;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/ffa_in_if.sv
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  alloc_size;
  logic signed [31:0] handle;
  modport source (output valid, command, alloc_size, handle, input ready);
  modport sink (input valid, command, alloc_size, handle, output ready);
endinterface

FILE: rtl/ffa_out_if.sv
interface ffa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] new_handle;
  modport source (output valid, status, new_handle, input ready);
  modport sink (input valid, status, new_handle, output ready);
endinterface

FILE: rtl/ffa_cfg_if.sv
interface ffa_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] memory_size;
  modport source (output valid, memory_size, input ready);
  modport sink (input valid, memory_size, output ready);
endinterface

FILE: rtl/ffa_ctrl.sv
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_A_RD, S_A_EVAL, S_A_FILL, S_E_LOAD, S_E_CLR,
    S_D_RD, S_D_EVAL, S_D_CLR, S_RES
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o.op = ffa_pkg::OP_NONE;
    ctl_o.res_code = ffa_pkg::ST_OK;
    case (state_q)
      S_INIT: begin
        if (sts_i.clr_end) begin
          state_d = S_IDLE;
        end else begin
          ctl_o.op = ffa_pkg::OP_D_CLR;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = ffa_pkg::OP_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.cmd)
          ffa_pkg::CMD_ALLOC: begin
            if (sts_i.no_hnd) begin
              ctl_o.op = ffa_pkg::OP_RES;
              ctl_o.res_code = ffa_pkg::ST_NO_HND;
              state_d = S_RES;
            end else if (sts_i.size_zero) begin
              ctl_o.op = ffa_pkg::OP_RES;
              ctl_o.res_code = ffa_pkg::ST_NO_SPACE;
              state_d = S_RES;
            end else begin
              state_d = S_A_RD;
            end
          end
          ffa_pkg::CMD_ERASE: begin
            if (!sts_i.hnd_ok) begin
              ctl_o.op = ffa_pkg::OP_RES;
              ctl_o.res_code = ffa_pkg::ST_ILLEGAL;
              state_d = S_RES;
            end else begin
              ctl_o.op = ffa_pkg::OP_TAB_RD;
              state_d = S_E_LOAD;
            end
          end
          ffa_pkg::CMD_DEFRAG: begin
            state_d = S_D_RD;
          end
          default: begin
            ctl_o.op = ffa_pkg::OP_RES;
            state_d = S_RES;
          end
        endcase
      end
      S_A_RD: begin
        if (sts_i.scan_end) begin
          ctl_o.op = ffa_pkg::OP_RES;
          ctl_o.res_code = ffa_pkg::ST_NO_SPACE;
          state_d = S_RES;
        end else begin
          ctl_o.op = ffa_pkg::OP_CELL_RD;
          state_d = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        ctl_o.op = ffa_pkg::OP_A_EVAL;
        state_d = sts_i.hit ? S_A_FILL : S_A_RD;
      end
      S_A_FILL: begin
        ctl_o.op = ffa_pkg::OP_FILL;
        if (sts_i.fill_last) state_d = S_RES;
      end
      S_E_LOAD: begin
        ctl_o.op = ffa_pkg::OP_E_LOAD;
        state_d = S_E_CLR;
      end
      S_E_CLR: begin
        ctl_o.op = ffa_pkg::OP_E_CLR;
        if (sts_i.fill_last) state_d = S_RES;
      end
      S_D_RD: begin
        if (sts_i.defrag_end) begin
          state_d = S_D_CLR;
        end else begin
          ctl_o.op = ffa_pkg::OP_CELL_RD;
          state_d = S_D_EVAL;
        end
      end
      S_D_EVAL: begin
        ctl_o.op = ffa_pkg::OP_D_EVAL;
        state_d = S_D_RD;
      end
      S_D_CLR: begin
        if (sts_i.clr_end) begin
          ctl_o.op = ffa_pkg::OP_RES;
          state_d = S_RES;
        end else begin
          ctl_o.op = ffa_pkg::OP_D_CLR;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          ctl_o.op = ffa_pkg::OP_PUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ffa_dp.sv
module ffa_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         command_i,
  input  logic [7:0]         alloc_size_i,
  input  logic signed [31:0] handle_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  ffa_pkg::ctl_t      ctl_i,
  output ffa_pkg::sts_t      sts_o,
  ffa_out_if.source          out_o
);

  localparam int AW = ffa_pkg::CELL_AW;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int HW = ffa_pkg::HND_W;

  logic [HW-1:0] cell_mem [ffa_pkg::MEM_CELLS];
  logic [AW-1:0] start_mem [ffa_pkg::HND_DEPTH];
  logic [AW-1:0] end_mem [ffa_pkg::HND_DEPTH];
  logic [ffa_pkg::HND_DEPTH-1:0] live_q;

  logic [7:0]    mem_size_q;
  logic [HW-1:0] last_q;
  logic [1:0]    cmd_q;
  logic [7:0]    size_q;
  logic [HW-1:0] hnd_q;
  logic          hnd_ok_q;
  logic [CW-1:0] idx_q, run_q, pos_q;
  logic [HW-1:0] prev_q, cell_rd_q;
  logic [AW-1:0] fill_k_q, fill_end_q, a_start_q, start_rd_q, end_rd_q;
  logic [1:0]    res_st_q;
  logic [HW-1:0] res_hnd_q;
  logic          out_valid_q;
  logic [1:0]    out_st_q;
  logic [HW-1:0] out_hnd_q;

  logic [CW-1:0] lim;
  logic [8:0]    run_nx;
  logic          hit;
  logic [CW-1:0] a_start;
  logic          hnd_ok;
  logic          cell_we, tab_s_we, tab_e_we;
  logic [AW-1:0] cell_wa;
  logic [HW-1:0] cell_wd, tab_wa;
  logic [AW-1:0] tab_wd_s, tab_wd_e;
  logic          fill_last;

  assign lim = (32'(mem_size_q) > ffa_pkg::MEM_CELLS) ? CW'(ffa_pkg::MEM_CELLS)
                                                      : CW'(mem_size_q);
  assign run_nx  = 9'(run_q) + 9'd1;
  assign hit     = (cell_rd_q == '0) && (run_nx == {1'b0, size_q});
  assign a_start = idx_q + CW'(1) - CW'(size_q);
  assign fill_last = (fill_k_q == fill_end_q);
  assign hnd_ok  = (handle_i[31:HW] == '0) && (handle_i[HW-1:0] != '0) &&
                   (32'(handle_i[HW-1:0]) <= ffa_pkg::MAX_HANDLES) &&
                   live_q[handle_i[HW-1:0]];

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.no_hnd     = (32'(last_q) >= ffa_pkg::MAX_HANDLES);
    sts_o.size_zero  = (size_q == '0);
    sts_o.hnd_ok     = hnd_ok_q;
    sts_o.scan_end   = (idx_q == lim);
    sts_o.hit        = hit;
    sts_o.fill_last  = fill_last;
    sts_o.defrag_end = (idx_q == CW'(ffa_pkg::MEM_CELLS));
    sts_o.clr_end    = (pos_q == CW'(ffa_pkg::MEM_CELLS));
    sts_o.out_free   = !out_valid_q || out_o.ready;
  end

  always_comb begin
    cell_we  = 1'b0;
    cell_wa  = fill_k_q;
    cell_wd  = '0;
    tab_s_we = 1'b0;
    tab_e_we = 1'b0;
    tab_wa   = last_q;
    tab_wd_s = a_start_q;
    tab_wd_e = fill_end_q;
    case (ctl_i.op)
      ffa_pkg::OP_FILL: begin
        cell_we = 1'b1;
        cell_wd = last_q;
        tab_s_we = fill_last;
        tab_e_we = fill_last;
      end
      ffa_pkg::OP_E_CLR: begin
        cell_we = 1'b1;
      end
      ffa_pkg::OP_D_EVAL: begin
        cell_we  = (cell_rd_q != '0);
        cell_wa  = pos_q[AW-1:0];
        cell_wd  = cell_rd_q;
        tab_wa   = cell_rd_q;
        tab_wd_s = pos_q[AW-1:0];
        tab_wd_e = pos_q[AW-1:0];
        tab_e_we = (cell_rd_q != '0);
        tab_s_we = (cell_rd_q != '0) && (prev_q != cell_rd_q);
      end
      ffa_pkg::OP_D_CLR: begin
        cell_we = 1'b1;
        cell_wa = pos_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (tab_s_we) start_mem[tab_wa] <= tab_wd_s;
    if (tab_e_we) end_mem[tab_wa] <= tab_wd_e;
    if (ctl_i.op == ffa_pkg::OP_CELL_RD) cell_rd_q <= cell_mem[idx_q[AW-1:0]];
    if (ctl_i.op == ffa_pkg::OP_TAB_RD) begin
      start_rd_q <= start_mem[hnd_q];
      end_rd_q   <= end_mem[hnd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      ffa_pkg::OP_LATCH: begin
        cmd_q    <= command_i;
        size_q   <= alloc_size_i;
        hnd_q    <= handle_i[HW-1:0];
        hnd_ok_q <= hnd_ok;
        idx_q    <= '0;
        run_q    <= '0;
        prev_q   <= '0;
      end
      ffa_pkg::OP_A_EVAL: begin
        run_q <= (cell_rd_q != '0) ? '0 : run_q + CW'(1);
        idx_q <= idx_q + CW'(1);
        if (hit) begin
          fill_k_q   <= a_start[AW-1:0];
          a_start_q  <= a_start[AW-1:0];
          fill_end_q <= idx_q[AW-1:0];
        end
      end
      ffa_pkg::OP_FILL, ffa_pkg::OP_E_CLR: begin
        fill_k_q <= fill_k_q + AW'(1);
        if (fill_last) begin
          res_st_q  <= ffa_pkg::ST_OK;
          res_hnd_q <= (ctl_i.op == ffa_pkg::OP_FILL) ? last_q : '0;
        end
      end
      ffa_pkg::OP_E_LOAD: begin
        fill_k_q   <= start_rd_q;
        fill_end_q <= end_rd_q;
      end
      ffa_pkg::OP_D_EVAL: begin
        idx_q  <= idx_q + CW'(1);
        prev_q <= cell_rd_q;
      end
      ffa_pkg::OP_RES: begin
        res_st_q  <= ctl_i.res_code;
        res_hnd_q <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q  <= 8'd128;
      last_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (cfg_we_i) mem_size_q <= cfg_data_i;
      if (ctl_i.op == ffa_pkg::OP_A_EVAL && hit) last_q <= last_q + HW'(1);
      if (ctl_i.op == ffa_pkg::OP_FILL && fill_last) live_q[last_q] <= 1'b1;
      if (ctl_i.op == ffa_pkg::OP_E_CLR && fill_last) live_q[hnd_q] <= 1'b0;
      if (ctl_i.op == ffa_pkg::OP_LATCH) begin
        pos_q <= '0;
      end else if (ctl_i.op == ffa_pkg::OP_D_CLR ||
                   (ctl_i.op == ffa_pkg::OP_D_EVAL && cell_rd_q != '0)) begin
        pos_q <= pos_q + CW'(1);
      end
      if (ctl_i.op == ffa_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == ffa_pkg::OP_PUSH) begin
      out_st_q  <= res_st_q;
      out_hnd_q <= res_hnd_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_st_q;
  assign out_o.new_handle = 8'(out_hnd_q);

endmodule

FILE: rtl/first_fit_allocator_with_compaction.sv
// First-fit block allocator over a 128-cell store with up to 255 handles.
// After reset the cell store is cleared one cell per cycle, and the first
// command is taken only once all 128 cells are clear.
// One command is worked at a time; a result transfer waits in an output
// register while the next command is taken. Allocate reads and checks the
// cells in turn up to the first fitting run, then writes one cell per
// cycle of the block. Erase clears one cell per cycle of the block after a
// table read. Defragment reads and checks every cell and then clears the
// freed top. The user must write memory_size over the cfg channel only
// while idle, which the block itself leaves unchecked.
module first_fit_allocator_with_compaction (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffa_in_if.sink    in_i,
  ffa_cfg_if.sink   cfg_i,
  ffa_out_if.source out_o
);

  ffa_pkg::ctl_t ctl;
  ffa_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ffa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (in_i.command),
    .alloc_size_i (in_i.alloc_size),
    .handle_i     (in_i.handle),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.memory_size),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_o        (out_o)
  );

endmodule
